/* sv/cascaded_averaging_history_log_unit_macros.svh */
// Assertion macros shared by the history log RTL.
`ifndef CASCADED_AVERAGING_HISTORY_LOG_UNIT_MACROS_SVH
`define CASCADED_AVERAGING_HISTORY_LOG_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAHL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CAHL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cahl_pkg.sv */
// Types and constants shared by the cascaded averaging history log.
`timescale 1ns / 1ps

package cahl_pkg;

    // Field widths fixed by the interface.
    localparam int REQ_W     = 2;
    localparam int SEL_W     = 2;
    localparam int OFF_W     = 6;
    localparam int SMP_W     = 16;
    localparam int LEN_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_COUNT = 3;
    localparam int CHANNELS  = 3;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_HIST = 2'd1;
    localparam logic [REQ_W-1:0] REQ_AVG  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2 = 2'd2;

    // Ring lengths after reset.
    localparam logic [LEN_W-1:0] LEVEL0_LEN_RST = 7'd60;
    localparam logic [LEN_W-1:0] LEVEL1_LEN_RST = 7'd60;
    localparam logic [LEN_W-1:0] LEVEL2_LEN_RST = 7'd24;

    // One input beat.
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [SEL_W-1:0] level_sel;
        logic [OFF_W-1:0] back_offset;
        logic [SMP_W-1:0] sample_pm1;
        logic [SMP_W-1:0] sample_pm25;
        logic [SMP_W-1:0] sample_pm10;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic             result_valid;
        logic [SMP_W-1:0] result_pm1;
        logic [SMP_W-1:0] result_pm25;
        logic [SMP_W-1:0] result_pm10;
    } t_out_beat;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* sv/cahl_store.sv */
// Sample memory: one write port and one registered read port.
`timescale 1ns / 1ps

module cahl_store #(
    parameter int DEPTH = 192,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/cahl_div.sv */
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
`timescale 1ns / 1ps

module cahl_div #(
    parameter int SUM_W = 23,
    parameter int DIV_W = 7
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [cahl_pkg::CHANNELS-1:0][SUM_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]                         i_divisor,
    output cahl_pkg::t_div_stat                      o_stat,
    output logic [cahl_pkg::CHANNELS-1:0][SUM_W-1:0] o_quot
);

    import cahl_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0]                r_cnt;
    logic                            r_done;
    logic [DIV_W-1:0]                r_div;
    logic [CHANNELS-1:0][SUM_W-1:0]  r_q;
    logic [CHANNELS-1:0][DIV_W-1:0]  r_rem;
    logic [CHANNELS-1:0][SUM_W-1:0]  n_q;
    logic [CHANNELS-1:0][DIV_W-1:0]  n_rem;
    logic [DIV_W:0]                  rem_sh;
    logic                            load;

    assign load = i_start && (r_cnt == '0);

    // One restoring step per lane: shift in the next dividend bit, try a subtract.
    always_comb begin
        rem_sh = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            rem_sh = {r_rem[c], r_q[c][SUM_W-1]};
            if (rem_sh >= {1'b0, r_div}) begin
                n_rem[c] = DIV_W'(rem_sh - {1'b0, r_div});
                n_q[c]   = {r_q[c][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[c] = DIV_W'(rem_sh);
                n_q[c]   = {r_q[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (load) begin
                r_cnt <= CNT_W'(SUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Quotient and remainder registers; the dividend shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule

/* sv/cascaded_averaging_history_log_unit.sv */
// Top level of the cascaded averaging history log.
`timescale 1ns / 1ps
`include "cascaded_averaging_history_log_unit_macros.svh"

// The block keeps LEVEL_COUNT rings of three-channel samples in one memory and serves one
// request at a time. A push writes level 0; when a ring wraps, the truncated mean of its
// filled entries is pushed into the next level in the same request. Each cascade step
// reads and sums the ring through the single memory read port, divides the sums in the
// bit-serial divider (SUM_W = VALUE_BITS + clog2(LEVEL_DEPTH + 1), 23 with the default
// parameters) and writes the mean into the next level. A history read with the offset
// out of range, a bad or unknown request and an average of an empty level still return
// a result beat. A new request is taken as soon as the previous result is in the output
// register, even while that result still waits to be taken. The sample memory is not
// cleared; entries are read only after they have been written.
module cascaded_averaging_history_log_unit #(
    parameter int LEVEL_DEPTH = 64,
    parameter int LEVEL_COUNT = 3,
    parameter int VALUE_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cahl_pkg::t_in_beat                  i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cahl_pkg::t_out_beat                 o_out_beat,
    input  logic                                i_cfg_we,
    input  logic [cahl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cahl_pkg::LEN_W-1:0]          i_cfg_wdata
);

    import cahl_pkg::*;

    localparam int POS_W  = $clog2(LEVEL_DEPTH);
    localparam int FC_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int LVL_W  = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int MEM_D  = LEVEL_COUNT * LEVEL_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);
    localparam int SUM_W  = VALUE_BITS + FC_W;
    localparam int HS_W   = ((FC_W > OFF_W) ? FC_W : OFF_W) + 1;
    localparam int MEM_W  = CHANNELS * VALUE_BITS;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PUSH  = 9'b000000010,
        S_HIST  = 9'b000000100,
        S_HWAIT = 9'b000001000,
        S_SUM   = 9'b000010000,
        S_LAST  = 9'b000100000,
        S_DIVGO = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state                              r_state, n_state;
    logic [LVL_W-1:0]                    r_lvl, n_lvl;
    logic [OFF_W-1:0]                    r_off, n_off;
    logic                                r_push, n_push;
    logic [CHANNELS-1:0][VALUE_BITS-1:0] r_vals, n_vals;
    logic [POS_W-1:0]                    r_idx, n_idx;
    logic [CHANNELS-1:0][SUM_W-1:0]      r_acc, n_acc;
    t_out_beat                           r_res, n_res;
    logic                                r_pend;
    logic                                r_out_valid;
    t_out_beat                           r_out_beat;

    // Per-level ring state and length registers.
    logic [POS_W-1:0] r_wpos [LEVEL_COUNT];
    logic [FC_W-1:0]  r_fill [LEVEL_COUNT];
    logic [LEN_W-1:0] r_len_cfg [CFG_COUNT];

    logic [FC_W-1:0]  cur_fill;
    logic [POS_W-1:0] cur_wpos;
    logic [FC_W-1:0]  cur_len;
    logic [LEN_W-1:0] len_raw;
    logic [FC_W-1:0]  push_fill_inc;
    logic [FC_W-1:0]  push_fill_new;
    logic [FC_W-1:0]  push_next;
    logic             push_wrap;
    logic [HS_W-1:0]  h_sum;
    logic [HS_W-1:0]  h_pos;
    logic             hist_hit;
    logic             sel_ok;
    logic [LVL_W-1:0] sel_idx;
    logic [FC_W-1:0]  sel_fill;

    logic                                mem_we;
    logic [ADDR_W-1:0]                   mem_waddr;
    logic [ADDR_W-1:0]                   mem_raddr;
    logic [CHANNELS-1:0][VALUE_BITS-1:0] mem_rdata;

    logic                                div_start;
    t_div_stat                           div_stat;
    logic [CHANNELS-1:0][SUM_W-1:0]      div_quot;

    // Memory address of an entry within a level.
    function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                                  input logic [POS_W-1:0] idx);
        return ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(idx);
    endfunction

    assign cur_fill = r_fill[r_lvl];
    assign cur_wpos = r_wpos[r_lvl];

    // Effective length of the current level: zero acts as one, clamped to the ring depth.
    always_comb begin
        len_raw = '0;
        if (int'(r_lvl) < CFG_COUNT) begin
            len_raw = r_len_cfg[CFG_IDX_W'(r_lvl)];
            if (len_raw == '0) begin
                cur_len = FC_W'(1);
            end else if (int'(len_raw) > LEVEL_DEPTH) begin
                cur_len = FC_W'(LEVEL_DEPTH);
            end else begin
                cur_len = FC_W'(len_raw);
            end
        end else begin
            cur_len = FC_W'(LEVEL_DEPTH);
        end
    end

    // Ring update for a push into the current level.
    always_comb begin
        push_fill_inc = cur_fill + FC_W'(1);
        push_fill_new = (push_fill_inc > cur_len) ? cur_len : push_fill_inc;
        push_next     = FC_W'(cur_wpos) + FC_W'(1);
        push_wrap     = (push_next >= cur_len);
    end

    // History slot: the write position never runs ahead of the fill count, so one
    // conditional subtract wraps the index.
    always_comb begin
        hist_hit = (HS_W'(r_off) < HS_W'(cur_fill));
        h_sum    = HS_W'(cur_wpos) + HS_W'(cur_fill) - HS_W'(1) - HS_W'(r_off);
        h_pos    = (h_sum >= HS_W'(cur_fill)) ? (h_sum - HS_W'(cur_fill)) : h_sum;
    end

    // Level addressed by an incoming read.
    assign sel_ok   = (int'(i_in_beat.level_sel) < LEVEL_COUNT);
    assign sel_idx  = sel_ok ? LVL_W'(i_in_beat.level_sel) : '0;
    assign sel_fill = r_fill[sel_idx];

    assign mem_waddr = addr_of(r_lvl, cur_wpos);

    // Request sequencer.
    always_comb begin
        n_state   = r_state;
        n_lvl     = r_lvl;
        n_off     = r_off;
        n_push    = r_push;
        n_vals    = r_vals;
        n_idx     = r_idx;
        n_acc     = r_acc;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_raddr = addr_of(r_lvl, r_idx);
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_lvl = sel_idx;
                    n_off = i_in_beat.back_offset;
                    n_res = '0;
                    case (i_in_beat.req_type)
                        REQ_PUSH: begin
                            n_lvl     = '0;
                            n_push    = 1'b1;
                            n_vals[0] = VALUE_BITS'(i_in_beat.sample_pm1);
                            n_vals[1] = VALUE_BITS'(i_in_beat.sample_pm25);
                            n_vals[2] = VALUE_BITS'(i_in_beat.sample_pm10);
                            n_state   = S_PUSH;
                        end
                        REQ_HIST: begin
                            n_state = sel_ok ? S_HIST : S_FIN;
                        end
                        REQ_AVG: begin
                            n_push = 1'b0;
                            if (sel_ok && (sel_fill != '0)) begin
                                n_idx   = '0;
                                n_acc   = '0;
                                n_state = S_SUM;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                mem_we = 1'b1;
                if (push_wrap && (int'(r_lvl) < LEVEL_COUNT - 1)) begin
                    n_idx   = '0;
                    n_acc   = '0;
                    n_state = S_SUM;
                end else begin
                    n_res              = '0;
                    n_res.result_valid = 1'b1;
                    n_state            = S_FIN;
                end
            end
            S_HIST: begin
                mem_raddr = addr_of(r_lvl, POS_W'(h_pos));
                n_state   = hist_hit ? S_HWAIT : S_FIN;
            end
            S_HWAIT: begin
                n_res.result_valid = 1'b1;
                n_res.result_pm1   = SMP_W'(mem_rdata[0]);
                n_res.result_pm25  = SMP_W'(mem_rdata[1]);
                n_res.result_pm10  = SMP_W'(mem_rdata[2]);
                n_state            = S_FIN;
            end
            S_SUM: begin
                if (r_pend) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        n_acc[c] = r_acc[c] + SUM_W'(mem_rdata[c]);
                    end
                end
                n_idx = r_idx + POS_W'(1);
                if (r_idx == POS_W'(cur_fill - FC_W'(1))) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    n_acc[c] = r_acc[c] + SUM_W'(mem_rdata[c]);
                end
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (r_push) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            n_vals[c] = VALUE_BITS'(div_quot[c]);
                        end
                        n_lvl   = r_lvl + LVL_W'(1);
                        n_state = S_PUSH;
                    end else begin
                        n_res.result_valid = 1'b1;
                        n_res.result_pm1   = SMP_W'(div_quot[0]);
                        n_res.result_pm25  = SMP_W'(div_quot[1]);
                        n_res.result_pm10  = SMP_W'(div_quot[2]);
                        n_state            = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_pend  <= (r_state == S_SUM);
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        r_off  <= n_off;
        r_push <= n_push;
        r_vals <= n_vals;
        r_idx  <= n_idx;
        r_acc  <= n_acc;
        r_res  <= n_res;
    end

    // Ring positions, fill counts and length registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVEL_COUNT; l++) begin
                r_wpos[l] <= '0;
                r_fill[l] <= '0;
            end
            r_len_cfg[CFG_LEVEL0] <= LEVEL0_LEN_RST;
            r_len_cfg[CFG_LEVEL1] <= LEVEL1_LEN_RST;
            r_len_cfg[CFG_LEVEL2] <= LEVEL2_LEN_RST;
        end else begin
            if (r_state == S_PUSH) begin
                r_fill[r_lvl] <= push_fill_new;
                r_wpos[r_lvl] <= push_wrap ? '0 : POS_W'(push_next);
            end
            if (i_cfg_we && (int'(i_cfg_idx) < CFG_COUNT)) begin
                r_len_cfg[i_cfg_idx] <= i_cfg_wdata;
            end
        end
    end

    // Output register: a finished result waits here while the next request runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && (!r_out_valid || !i_out_stall)) begin
            r_out_beat <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    cahl_store #(
        .DEPTH (MEM_D),
        .WIDTH (MEM_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_vals),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cahl_div #(
        .SUM_W (SUM_W),
        .DIV_W (FC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (cur_fill),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // The write position of a level never runs ahead of its fill count.
    `CAHL_ASSERT_SAME(a_wpos_within_fill, i_clk, i_rst_n, 1'b1, FC_W'(cur_wpos) <= cur_fill, "write position beyond fill count")
    // The divider is free whenever a division is launched.
    `CAHL_ASSERT_SAME(a_div_free_at_start, i_clk, i_rst_n, r_state == S_DIVGO, !div_stat.busy, "divider launched while busy")
    // A launched division is running in the following cycle.
    `CAHL_ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, r_state == S_DIVGO, div_stat.busy, "divider did not start")
    // No division is left running once a result is ready.
    `CAHL_ASSERT_SAME(a_div_idle_at_fin, i_clk, i_rst_n, r_state == S_FIN, !div_stat.busy, "result ready while divider busy")

endmodule
